### rtl/double_ended_queue_assert.svh
// assertion macros used by the queue rtl
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue check failed");

// next-cycle implication, checked outside reset
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

### rtl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

    localparam int unsigned DataWidth = 32;

    typedef enum logic [1:0] {
        FN_PUSH_FRONT = 2'd0,
        FN_PUSH_BACK  = 2'd1,
        FN_POP_FRONT  = 2'd2,
        FN_POP_BACK   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-request outcome handed from the pointer unit to the pipeline
    typedef struct packed {
        logic    pop_ok;
        t_status status;
    } t_req_info;

endpackage

### rtl/dq_ram.sv
`timescale 1ns / 1ps

module dq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/dq_ptr.sv
`timescale 1ns / 1ps

module dq_ptr #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  dq_pkg::t_func              i_func,
    output logic                       o_we,
    output logic                       o_re,
    output logic [$clog2(DEPTH)-1:0]   o_addr,
    output dq_pkg::t_req_info          o_info,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LastIdx = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

    logic [PW-1:0] r_front, n_front;
    logic [PW-1:0] r_back, n_back;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] front_inc, front_dec, back_inc, back_dec;
    logic          full, empty;

    assign full      = (r_count == FullCnt);
    assign empty     = (r_count == '0);
    assign front_inc = (r_front == LastIdx) ? '0 : r_front + PW'(1);
    assign front_dec = (r_front == '0) ? LastIdx : r_front - PW'(1);
    assign back_inc  = (r_back == LastIdx) ? '0 : r_back + PW'(1);
    assign back_dec  = (r_back == '0) ? LastIdx : r_back - PW'(1);

    always_comb begin
        n_front        = r_front;
        n_back         = r_back;
        n_count        = r_count;
        o_we           = 1'b0;
        o_re           = 1'b0;
        o_addr         = r_front;
        o_info.pop_ok  = 1'b0;
        o_info.status  = dq_pkg::ST_OK;
        case (i_func)
            dq_pkg::FN_PUSH_FRONT: begin
                if (full) begin
                    o_info.status = dq_pkg::ST_FULL;
                end else begin
                    o_we    = i_go;
                    o_addr  = front_dec;
                    n_front = front_dec;
                    n_count = r_count + CW'(1);
                end
            end
            dq_pkg::FN_PUSH_BACK: begin
                if (full) begin
                    o_info.status = dq_pkg::ST_FULL;
                end else begin
                    o_we    = i_go;
                    o_addr  = r_back;
                    n_back  = back_inc;
                    n_count = r_count + CW'(1);
                end
            end
            dq_pkg::FN_POP_FRONT: begin
                if (empty) begin
                    o_info.status = dq_pkg::ST_EMPTY;
                end else begin
                    o_re          = i_go;
                    o_info.pop_ok = 1'b1;
                    o_addr        = r_front;
                    n_front       = front_inc;
                    n_count       = r_count - CW'(1);
                end
            end
            dq_pkg::FN_POP_BACK: begin
                if (empty) begin
                    o_info.status = dq_pkg::ST_EMPTY;
                end else begin
                    o_re          = i_go;
                    o_info.pop_ok = 1'b1;
                    o_addr        = back_dec;
                    n_back        = back_dec;
                    n_count       = r_count - CW'(1);
                end
            end
            default: begin
                o_info.status = dq_pkg::ST_OK;
            end
        endcase
    end

    assign o_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_go) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

endmodule

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// a result goes from its input transfer through the store read, then the output register
// throughput: one request per cycle while o_stall is low; pointers and count update at the
// input transfer, so the single store port is touched at most once per cycle and needs no forwarding
// reset: pointers and count clear, pipeline empties; the store is not cleared and needs no pass
// o_stall rises only while both the read stage and the output register are held by i_stall

module double_ended_queue #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_func,
    input  logic signed [31:0]         i_push_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [31:0]         o_pop_value,
    output logic [1:0]                 o_status,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic                             accept;
    logic                             adv;
    logic                             ram_we, ram_re;
    logic [PW-1:0]                    ram_addr;
    logic [dq_pkg::DataWidth-1:0]     ram_rdata;
    dq_pkg::t_req_info                req_info;
    logic [CW-1:0]                    req_count;

    logic                             r_s1_valid, n_s1_valid;
    dq_pkg::t_req_info                r_s1_info;
    logic [CW-1:0]                    r_s1_count;
    logic                             r_out_valid, n_out_valid;
    logic [dq_pkg::DataWidth-1:0]     r_out_pop_value;
    dq_pkg::t_status                  r_out_status;
    logic [CW-1:0]                    r_out_count;

    assign o_stall = r_s1_valid & r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;
    // read stage moves on when the output register is free or being emptied
    assign adv     = r_s1_valid & (~r_out_valid | ~i_stall);

    dq_ptr #(
        .DEPTH(DEPTH)
    ) u_ptr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (accept),
        .i_func  (dq_pkg::t_func'(i_func)),
        .o_we    (ram_we),
        .o_re    (ram_re),
        .o_addr  (ram_addr),
        .o_info  (req_info),
        .o_count (req_count)
    );

    dq_ram #(
        .WIDTH(dq_pkg::DataWidth),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_push_value),
        .o_rdata (ram_rdata)
    );

    assign n_s1_valid  = accept | (r_s1_valid & ~adv);
    assign n_out_valid = adv | (r_out_valid & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // read data stays put until the next pop read, which only issues as this stage drains
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info  <= req_info;
            r_s1_count <= req_count;
        end
        if (adv) begin
            r_out_pop_value <= r_s1_info.pop_ok ? ram_rdata : '0;
            r_out_status    <= r_s1_info.status;
            r_out_count     <= r_s1_count;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pop_value = r_out_pop_value;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;

`include "double_ended_queue_assert.svh"

    `DQ_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, o_valid, o_count <= CW'(DEPTH))
    `DQ_ASSERT_IMPL(a_empty_zero, i_clk, i_rst_n, o_valid && o_status == dq_pkg::ST_EMPTY, o_pop_value == '0 && o_count == '0)
    `DQ_ASSERT_IMPL(a_full_count, i_clk, i_rst_n, o_valid && o_status == dq_pkg::ST_FULL, o_count == CW'(DEPTH))
    `DQ_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, accept, r_s1_valid)

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int QDEPTH = 256;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    typedef struct {
        logic [31:0]      pop_value;
        dq_pkg::t_status  status;
        logic [CNT_W-1:0] count;
    } t_dq_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_func;
    logic signed [31:0] i_push_value;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_pop_value;
    logic [1:0]         o_status;
    logic [CNT_W-1:0]   o_count;

    // shadow copy of the queue contents
    logic [31:0]      slot_mem [QDEPTH];
    logic [PTR_W-1:0] head_idx = '0;
    logic [PTR_W-1:0] tail_idx = '0;
    int               held = 0;

    t_dq_result pending_results[$];

    int  mismatch_cnt = 0;
    int  req_cnt = 0;
    int  result_cnt = 0;
    int  empty_pops = 0;
    int  full_pushes = 0;
    int  peak_fill = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  hold_cycles = 0;

    double_ended_queue #(
        .DEPTH(QDEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_push_value(i_push_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pop_value (o_pop_value),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic t_dq_result deque_apply(dq_pkg::t_func fn, logic [31:0] val);
        t_dq_result r;
        r.pop_value = '0;
        r.status    = dq_pkg::ST_OK;
        case (fn)
            dq_pkg::FN_PUSH_FRONT, dq_pkg::FN_PUSH_BACK: begin
                if (held == QDEPTH) begin
                    r.status = dq_pkg::ST_FULL;
                    full_pushes++;
                end else if (fn == dq_pkg::FN_PUSH_FRONT) begin
                    head_idx           = head_idx - 1'b1;
                    slot_mem[head_idx] = val;
                    held++;
                end else begin
                    slot_mem[tail_idx] = val;
                    tail_idx           = tail_idx + 1'b1;
                    held++;
                end
            end
            default: begin
                if (held == 0) begin
                    r.status = dq_pkg::ST_EMPTY;
                    empty_pops++;
                end else if (fn == dq_pkg::FN_POP_FRONT) begin
                    r.pop_value = slot_mem[head_idx];
                    head_idx    = head_idx + 1'b1;
                    held--;
                end else begin
                    tail_idx    = tail_idx - 1'b1;
                    r.pop_value = slot_mem[tail_idx];
                    held--;
                end
            end
        endcase
        if (held > peak_fill)
            peak_fill = held;
        r.count = held[CNT_W-1:0];
        return r;
    endfunction

    // expectation is formed at the input transfer
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            pending_results.push_back(deque_apply(dq_pkg::t_func'(i_func), i_push_value));
            req_cnt++;
        end
    end

    always @(posedge i_clk) begin
        t_dq_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            result_cnt++;
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: unexpected result value %h status %0d count %0d",
                             $realtime, o_pop_value, o_status, o_count);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_pop_value !== exp_res.pop_value || o_status !== exp_res.status ||
                    o_count !== exp_res.count) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: expected value %h status %0d count %0d, got %h %0d %0d",
                                 $realtime, exp_res.pop_value, exp_res.status,
                                 exp_res.count, o_pop_value, o_status, o_count);
                end
            end
        end
    end

    // receiver: random stall before each transfer, plus a long hold on request
    initial begin
        int gap;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            gap = rx_idle_on ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    task automatic send_req(dq_pkg::t_func fn, logic [31:0] val);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= fn;
        i_push_value <= val;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic dq_pkg::t_func pick_push();
        return $urandom_range(0, 1) ? dq_pkg::FN_PUSH_BACK : dq_pkg::FN_PUSH_FRONT;
    endfunction

    function automatic dq_pkg::t_func pick_pop();
        return $urandom_range(0, 1) ? dq_pkg::FN_POP_BACK : dq_pkg::FN_POP_FRONT;
    endfunction

    // extremes, both ends, and pops on an empty queue
    task automatic test_directed();
        send_req(dq_pkg::FN_POP_FRONT, 32'h1234_5678);
        send_req(dq_pkg::FN_POP_BACK, 32'hffff_ffff);
        send_req(dq_pkg::FN_PUSH_FRONT, 32'h8000_0000);
        send_req(dq_pkg::FN_PUSH_BACK, 32'h7fff_ffff);
        send_req(dq_pkg::FN_PUSH_FRONT, 32'hffff_ffff);
        send_req(dq_pkg::FN_PUSH_BACK, 32'h0000_0000);
        send_req(dq_pkg::FN_PUSH_FRONT, 32'h0000_0001);
        send_req(dq_pkg::FN_PUSH_BACK, 32'haaaa_aaaa);
        send_req(dq_pkg::FN_PUSH_FRONT, 32'h5555_5555);
        send_req(dq_pkg::FN_POP_FRONT, 32'hdead_beef);
        send_req(dq_pkg::FN_POP_BACK, 32'h0000_0000);
        send_req(dq_pkg::FN_POP_FRONT, 32'h8000_0000);
        send_req(dq_pkg::FN_POP_BACK, 32'h7fff_ffff);
        send_req(dq_pkg::FN_POP_FRONT, 32'h0);
        send_req(dq_pkg::FN_POP_BACK, 32'h0);
        send_req(dq_pkg::FN_POP_FRONT, 32'h0);
        send_req(dq_pkg::FN_POP_BACK, 32'h5555_5555);
        send_req(dq_pkg::FN_POP_FRONT, 32'haaaa_aaaa);
        wait_drain();
    endtask

    // fill to the brim, push onto a full queue at both ends, then empty it
    task automatic test_fill_and_empty();
        int n_push;
        n_push = QDEPTH - held;
        for (int i = 0; i < n_push; i++)
            send_req(pick_push(), pick_value());
        send_req(dq_pkg::FN_PUSH_FRONT, pick_value());
        send_req(dq_pkg::FN_PUSH_BACK, pick_value());
        wait_drain();
        for (int i = 0; i < QDEPTH; i++)
            send_req(pick_pop(), pick_value());
        send_req(dq_pkg::FN_POP_FRONT, pick_value());
        wait_drain();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        tx_idle_on  = 1'b0;
        hold_cycles = 60;
        for (int i = 0; i < 40; i++)
            send_req($urandom_range(0, 3) != 0 ? pick_push() : pick_pop(), pick_value());
        wait_drain();
        tx_idle_on = 1'b1;
    endtask

    // random walk of the fill level towards a moving target
    task automatic test_random_walk(int n_items);
        int target;
        int settle_left;
        int push_pct;
        settle_left = 0;
        target      = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 64 == 0) begin
                tx_idle_on = $urandom_range(0, 3) != 0;
                rx_idle_on = $urandom_range(0, 3) != 0;
            end
            if (i % 200 == 199)
                wait_drain();
            if (settle_left == 0) begin
                case ($urandom_range(0, 4))
                    0: target = 0;
                    1: target = 3;
                    2: target = 64;
                    3: target = 200;
                    default: target = QDEPTH;
                endcase
                settle_left = $urandom_range(10, 30);
            end
            if (held < target)
                push_pct = 85;
            else if (held > target)
                push_pct = 15;
            else begin
                push_pct = 50;
                settle_left--;
            end
            if ($urandom_range(1, 100) <= push_pct)
                send_req(pick_push(), pick_value());
            else
                send_req(pick_pop(), pick_value());
        end
        wait_drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_func       <= dq_pkg::FN_PUSH_FRONT;
        i_push_value <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_and_empty();
        test_backpressure();
        test_random_walk(980);

        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            mismatch_cnt += pending_results.size();
        end
        $display("%0d requests sent, %0d results checked, peak fill %0d of %0d",
                 req_cnt, result_cnt, peak_fill, QDEPTH);
        $display("%0d pops on an empty queue, %0d pushes onto a full queue, %0d mismatches",
                 empty_pops, full_pushes, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
